// ===== hw/rtl/qdta_pkg.sv =====
// ---------------------------------------------------------------------------
// qdta_pkg
// shared types and codes for the queue depth threshold alert unit
// ---------------------------------------------------------------------------
package qdta_pkg;

  // event codes on the result channel
  typedef enum logic [1:0] {
    EV_UP       = 2'd0,
    EV_EXCEEDED = 2'd1,
    EV_DOWN     = 2'd2
  } ev_kind_t;

  // which alarm an event belongs to
  localparam logic METRIC_SIZE  = 1'b0;
  localparam logic METRIC_COUNT = 1'b1;

  // input kinds
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COUNT_UP   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COUNT_DOWN = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_UP    = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_DOWN  = 2'd3;

  // event slots of one input, in delivery order
  localparam int unsigned EVT_SLOTS = 4;
  localparam int unsigned EB_SIZE_MAIN  = 0;  // size up or size down
  localparam int unsigned EB_SIZE_EXC   = 1;  // size exceeded
  localparam int unsigned EB_COUNT_MAIN = 2;  // count up or count down
  localparam int unsigned EB_COUNT_EXC  = 3;  // count exceeded

  localparam int unsigned MSG_BYTES_BITS = 32;

  // events raised by one input
  typedef struct packed {
    logic                 deq;
    logic [EVT_SLOTS-1:0] mask;
  } evt_t;

endpackage

// ===== hw/rtl/queue_depth_threshold_alert_unit.sv =====
// ---------------------------------------------------------------------------
// queue_depth_threshold_alert_unit
// running queue depth (messages and bytes) with two hysteresis alarms
// ---------------------------------------------------------------------------
// usage
//   input beat: one enqueue (in_kind 0) or dequeue (in_kind 1) of a message of
//   in_message_bytes; the totals saturate on enqueue and clamp at zero on dequeue
//   output beat: one alarm event (up, exceeded, down) for the size or count
//   alarm with the totals after the update; out_last marks the final event of
//   an input, an input that raises no event gives no beat
//   config: cfg_wr_en/cfg_index/cfg_data, written while the unit is idle
// result path and throughput
//   first event of an input goes to the result register, or skid entry if busy
//   one input per cycle unless in_stall; an input with n events holds the output
//   for n beats: the single result register sends one event per unstalled cycle
// reset
//   synchronous rst_n clears totals and config, arms both alarms, empties output
// backpressure
//   a result waiting under out_stall does not block input: one more event
//   group lands in the skid entry, and only then is in_stall raised
// ---------------------------------------------------------------------------
module queue_depth_threshold_alert_unit #(
  parameter int COUNT_BITS = 32,
  parameter int SIZE_BITS  = 48
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // config write port
  input  logic                                cfg_wr_en,
  input  logic [qdta_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [((COUNT_BITS > SIZE_BITS) ? COUNT_BITS : SIZE_BITS)-1:0] cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic [qdta_pkg::MSG_BYTES_BITS-1:0] in_message_bytes,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_event_kind,
  output logic                                out_metric,
  output logic [COUNT_BITS-1:0]               out_depth_count,
  output logic [SIZE_BITS-1:0]                out_depth_bytes,
  output logic                                out_last
);
  import qdta_pkg::*;

  localparam int CFG_W = (COUNT_BITS > SIZE_BITS) ? COUNT_BITS : SIZE_BITS;

  logic                  in_acc;
  logic                  skid_full;
  evt_t                  evt;
  logic [COUNT_BITS-1:0] count_nxt;
  logic [SIZE_BITS-1:0]  bytes_nxt;

  // stall only once the skid entry is taken
  assign in_stall = skid_full;
  assign in_acc   = in_valid && !in_stall;

  // totals and alarm state, updated on every accepted beat
  qdta_tracker #(
    .COUNT_BITS (COUNT_BITS),
    .SIZE_BITS  (SIZE_BITS),
    .CFG_W      (CFG_W)
  ) u_tracker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .take          (in_acc),
    .kind          (in_kind),
    .message_bytes (in_message_bytes),
    .evt           (evt),
    .count_nxt     (count_nxt),
    .bytes_nxt     (bytes_nxt)
  );

  // only inputs that raise at least one event enter the output stage
  qdta_event_out #(
    .COUNT_BITS (COUNT_BITS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_event_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .push_valid      (in_acc && (evt.mask != '0)),
    .push_evt        (evt),
    .push_count      (count_nxt),
    .push_bytes      (bytes_nxt),
    .full            (skid_full),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_metric      (out_metric),
    .out_depth_count (out_depth_count),
    .out_depth_bytes (out_depth_bytes),
    .out_last        (out_last)
  );

endmodule

// ===== hw/rtl/qdta_tracker.sv =====
// ---------------------------------------------------------------------------
// qdta_tracker
// config registers, running depth totals and the two hysteresis alarms
// ---------------------------------------------------------------------------
module qdta_tracker #(
  parameter int COUNT_BITS = 32,
  parameter int SIZE_BITS  = 48,
  parameter int CFG_W      = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [qdta_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_W-1:0]                  cfg_data,
  input  logic                              take,
  input  logic                              kind,
  input  logic [qdta_pkg::MSG_BYTES_BITS-1:0] message_bytes,
  output qdta_pkg::evt_t                    evt,
  output logic [COUNT_BITS-1:0]             count_nxt,
  output logic [SIZE_BITS-1:0]              bytes_nxt
);
  import qdta_pkg::*;

  localparam int SUM_W = ((SIZE_BITS > MSG_BYTES_BITS) ? SIZE_BITS : MSG_BYTES_BITS) + 1;

  logic [COUNT_BITS-1:0] count_up_r, count_down_req_r;
  logic [SIZE_BITS-1:0]  size_up_r, size_down_req_r;
  logic [COUNT_BITS-1:0] held_count_r;
  logic [SIZE_BITS-1:0]  held_bytes_r;
  logic                  count_armed_r, size_armed_r;
  logic                  count_armed_nxt, size_armed_nxt;

  logic [SUM_W-1:0]      held_ext, msg_ext, sum, diff, size_max_ext;
  logic [COUNT_BITS-1:0] cdown;
  logic [SIZE_BITS-1:0]  sdown;
  logic                  compat, s_fire, c_fire;

  // effective re-arm levels
  always_comb begin
    cdown = (count_down_req_r == '0 || count_down_req_r >= count_up_r) ?
            (count_up_r >> 1) : count_down_req_r;
    sdown = (size_down_req_r == '0 || size_down_req_r >= size_up_r) ?
            (size_up_r >> 1) : size_down_req_r;
    compat = (count_down_req_r == '0) && (size_down_req_r == '0);
  end

  // saturating / clamping totals
  always_comb begin
    held_ext     = SUM_W'(held_bytes_r);
    msg_ext      = SUM_W'(message_bytes);
    size_max_ext = SUM_W'({SIZE_BITS{1'b1}});
    sum          = held_ext + msg_ext;
    diff         = held_ext - msg_ext;
    if (kind == KIND_ENQ) begin
      bytes_nxt = (sum > size_max_ext) ? {SIZE_BITS{1'b1}} : sum[SIZE_BITS-1:0];
      count_nxt = (&held_count_r) ? held_count_r : held_count_r + COUNT_BITS'(1);
    end else begin
      bytes_nxt = (held_ext > msg_ext) ? diff[SIZE_BITS-1:0] : '0;
      count_nxt = (held_count_r == '0) ? '0 : held_count_r - COUNT_BITS'(1);
    end
  end

  // alarm decisions
  always_comb begin
    evt      = '0;
    evt.deq  = (kind == KIND_DEQ);
    if (kind == KIND_ENQ) begin
      s_fire = size_armed_r && (size_up_r != '0) && (bytes_nxt >= size_up_r);
      c_fire = count_armed_r && (count_up_r != '0) && (count_nxt >= count_up_r);
      evt.mask[EB_SIZE_EXC]  = s_fire && compat;
      evt.mask[EB_COUNT_EXC] = c_fire && compat;
    end else begin
      s_fire = !size_armed_r && (size_up_r != '0) && (bytes_nxt <= sdown);
      c_fire = !count_armed_r && (count_up_r != '0) && (count_nxt <= cdown);
    end
    evt.mask[EB_SIZE_MAIN]  = s_fire;
    evt.mask[EB_COUNT_MAIN] = c_fire;
    size_armed_nxt  = s_fire ? (kind == KIND_DEQ) : size_armed_r;
    count_armed_nxt = c_fire ? (kind == KIND_DEQ) : count_armed_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_up_r       <= '0;
      count_down_req_r <= '0;
      size_up_r        <= '0;
      size_down_req_r  <= '0;
      held_count_r     <= '0;
      held_bytes_r     <= '0;
      count_armed_r    <= 1'b1;
      size_armed_r     <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_COUNT_UP:   count_up_r       <= cfg_data[COUNT_BITS-1:0];
          REG_COUNT_DOWN: count_down_req_r <= cfg_data[COUNT_BITS-1:0];
          REG_SIZE_UP:    size_up_r        <= cfg_data[SIZE_BITS-1:0];
          REG_SIZE_DOWN:  size_down_req_r  <= cfg_data[SIZE_BITS-1:0];
          default: ;
        endcase
      end
      if (take) begin
        held_count_r  <= count_nxt;
        held_bytes_r  <= bytes_nxt;
        count_armed_r <= count_armed_nxt;
        size_armed_r  <= size_armed_nxt;
      end
    end
  end

endmodule

// ===== hw/rtl/qdta_event_out.sv =====
// ---------------------------------------------------------------------------
// qdta_event_out
// result register plus skid entry; sends the events of one input one per beat
// ---------------------------------------------------------------------------
module qdta_event_out #(
  parameter int COUNT_BITS = 32,
  parameter int SIZE_BITS  = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  input  qdta_pkg::evt_t        push_evt,
  input  logic [COUNT_BITS-1:0] push_count,
  input  logic [SIZE_BITS-1:0]  push_bytes,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_event_kind,
  output logic                  out_metric,
  output logic [COUNT_BITS-1:0] out_depth_count,
  output logic [SIZE_BITS-1:0]  out_depth_bytes,
  output logic                  out_last
);
  import qdta_pkg::*;

  logic                  head_valid_r, skid_valid_r;
  evt_t                  head_evt_r, skid_evt_r;
  logic [COUNT_BITS-1:0] head_count_r, skid_count_r;
  logic [SIZE_BITS-1:0]  head_bytes_r, skid_bytes_r;

  logic [EVT_SLOTS-1:0]  sel, rem;
  logic                  out_acc, head_free;
  ev_kind_t              ek;

  always_comb begin
    sel       = head_evt_r.mask & (~head_evt_r.mask + EVT_SLOTS'(1));
    rem       = head_evt_r.mask & ~sel;
    out_acc   = head_valid_r && !out_stall;
    head_free = !head_valid_r || (out_acc && (rem == '0));
    if (sel[EB_SIZE_EXC] || sel[EB_COUNT_EXC]) begin
      ek = EV_EXCEEDED;
    end else if (head_evt_r.deq) begin
      ek = EV_DOWN;
    end else begin
      ek = EV_UP;
    end
  end

  assign full            = skid_valid_r;
  assign out_valid       = head_valid_r;
  assign out_event_kind  = ek;
  assign out_metric      = (sel[EB_COUNT_MAIN] || sel[EB_COUNT_EXC]) ? METRIC_COUNT
                                                                     : METRIC_SIZE;
  assign out_depth_count = head_count_r;
  assign out_depth_bytes = head_bytes_r;
  assign out_last        = (rem == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (head_free) begin
      head_valid_r <= skid_valid_r || push_valid;
      skid_valid_r <= 1'b0;
    end else if (push_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_free) begin
      if (skid_valid_r) begin
        head_evt_r   <= skid_evt_r;
        head_count_r <= skid_count_r;
        head_bytes_r <= skid_bytes_r;
      end else begin
        head_evt_r   <= push_evt;
        head_count_r <= push_count;
        head_bytes_r <= push_bytes;
      end
    end else begin
      if (out_acc) begin
        head_evt_r.mask <= rem;
      end
      if (push_valid) begin
        skid_evt_r   <= push_evt;
        skid_count_r <= push_count;
        skid_bytes_r <= push_bytes;
      end
    end
  end

endmodule

// ===== hw/rtl/qdta_checker.sv =====
// ---------------------------------------------------------------------------
// qdta_checker
// port-level checks of the queue depth threshold alert unit
// ---------------------------------------------------------------------------
module qdta_checker #(
  parameter int COUNT_BITS = 32,
  parameter int SIZE_BITS  = 48
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [1:0]            out_event_kind,
  input logic                  out_metric,
  input logic [COUNT_BITS-1:0] out_depth_count,
  input logic [SIZE_BITS-1:0]  out_depth_bytes,
  input logic                  out_last
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_kind) &&
      $stable(out_metric) && $stable(out_depth_count) &&
      $stable(out_depth_bytes) && $stable(out_last))
    else $error("stalled result changed");

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // rest of an event group follows with no gap
  a_group_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("event group broken");

  // input is never held off while the output is empty
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind queue_depth_threshold_alert_unit qdta_checker #(
  .COUNT_BITS (COUNT_BITS),
  .SIZE_BITS  (SIZE_BITS)
) u_qdta_checker (.*);
